>>> rtl/fir_linear_convolution_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef FIR_LINEAR_CONVOLUTION_UNIT_DEFINES_SVH
`define FIR_LINEAR_CONVOLUTION_UNIT_DEFINES_SVH

// Checked outside reset only.
`define FLC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define FLC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/flc_pkg.sv
`default_nettype none
package flc_pkg;

  localparam int ACTION_W   = 2;
  localparam int TAP_IDX_W  = 4;
  localparam int VALUE_W    = 16;
  localparam int OUT_W      = 36;
  localparam int TAPCNT_W   = 5;

  localparam logic [TAPCNT_W-1:0] TAPCNT_RESET = 5'd10;

  localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FLUSH  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_MAC,
    ST_ADD,
    ST_RESULT
  } flc_state_t;

  typedef struct packed {
    logic coef_wr;
    logic shift_en;
    logic shift_zero;
    logic clear_dl;
    logic mac_clear;
    logic mac_step;
    logic acc_final;
    logic load_rem;
    logic dec_rem;
    logic out_load;
    logic out_last;
  } flc_cmd_t;

  typedef struct packed {
    logic n_is_one;
    logic rem_one;
    logic mac_last;
  } flc_sts_t;

endpackage
`default_nettype wire

>>> rtl/flc_if.sv
`default_nettype none
interface flc_in_if import flc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic [TAP_IDX_W-1:0]       tap_index;
  logic signed [VALUE_W-1:0]  value;
  modport source (output valid, action, tap_index, value, input ready);
  modport sink   (input valid, action, tap_index, value, output ready);
endinterface

interface flc_out_if import flc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [OUT_W-1:0]    filtered;
  logic                       is_last;
  modport source (output valid, filtered, is_last, input ready);
  modport sink   (input valid, filtered, is_last, output ready);
endinterface

interface flc_cfg_if import flc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [TAPCNT_W-1:0]        data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

>>> rtl/flc_ctrl.sv
`default_nettype none
module flc_ctrl import flc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [ACTION_W-1:0] in_action,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  output flc_cmd_t            cmd,
  input  flc_sts_t            sts
);

  flc_state_t state_r, state_nxt;
  logic       flush_r, flush_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      flush_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      flush_r     <= flush_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    flush_nxt = flush_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_action)
            ACT_LOAD: cmd.coef_wr = 1'b1;
            ACT_SAMPLE: begin
              cmd.shift_en  = 1'b1;
              cmd.mac_clear = 1'b1;
              flush_nxt     = 1'b0;
              state_nxt     = ST_MAC;
            end
            ACT_FLUSH: begin
              if (sts.n_is_one) begin
                cmd.clear_dl = 1'b1;
              end else begin
                cmd.load_rem = 1'b1;
                flush_nxt    = 1'b1;
                state_nxt    = ST_SHIFT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SHIFT: begin
        cmd.shift_en   = 1'b1;
        cmd.shift_zero = 1'b1;
        cmd.mac_clear  = 1'b1;
        state_nxt      = ST_MAC;
      end
      ST_MAC: begin
        cmd.mac_step = 1'b1;
        if (sts.mac_last) state_nxt = ST_ADD;
      end
      ST_ADD: begin
        cmd.acc_final = 1'b1;
        state_nxt     = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = flush_r && sts.rem_one;
          if (flush_r) begin
            cmd.dec_rem = 1'b1;
            if (sts.rem_one) begin
              cmd.clear_dl = 1'b1;
              state_nxt    = ST_IDLE;
            end else begin
              state_nxt    = ST_SHIFT;
            end
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

endmodule
`default_nettype wire

>>> rtl/flc_datapath.sv
`default_nettype none
module flc_datapath import flc_pkg::*; #(
  parameter int MAX_TAPS    = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr,
  input  logic [TAPCNT_W-1:0]       cfg_data,
  input  logic [TAP_IDX_W-1:0]      tap_index,
  input  logic signed [VALUE_W-1:0] value,
  input  flc_cmd_t                  cmd,
  output flc_sts_t                  sts,
  output logic signed [OUT_W-1:0]   filtered,
  output logic                      is_last
);

  localparam int CW = $clog2(MAX_TAPS + 1);
  localparam int PW = 2 * SAMPLE_BITS;
  localparam int EW = (PW > OUT_W) ? PW : OUT_W;

  logic signed [SAMPLE_BITS-1:0] coef_r [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] dl_r   [MAX_TAPS];
  logic [TAPCNT_W-1:0]           tap_count_r;
  logic [CW-1:0]                 n_act;
  logic [CW-1:0]                 step_r;
  logic [CW-1:0]                 rem_r;
  logic signed [SAMPLE_BITS-1:0] samp;
  logic signed [PW-1:0]          prod_full;
  logic signed [PW-1:0]          prod_r;
  logic signed [EW-1:0]          prod_ext;
  logic [OUT_W-1:0]              acc_r;
  logic signed [OUT_W-1:0]       filtered_r;
  logic                          is_last_r;
  logic                          tap_en;

  // input word truncated to its low SAMPLE_BITS bits, or zero-extended when SAMPLE_BITS exceeds VALUE_W
  if (SAMPLE_BITS <= VALUE_W) begin : g_narrow
    assign samp = value[SAMPLE_BITS-1:0];
  end else begin : g_wide
    assign samp = {{(SAMPLE_BITS-VALUE_W){1'b0}}, value};
  end

  // active tap count, clamped to 1..MAX_TAPS
  always_comb begin
    if (tap_count_r == '0)
      n_act = CW'(1);
    else if (32'(tap_count_r) > MAX_TAPS)
      n_act = CW'(MAX_TAPS);
    else
      n_act = CW'(tap_count_r);
  end

  assign sts.n_is_one = (n_act == CW'(1));
  assign sts.rem_one  = (rem_r == CW'(1));
  assign sts.mac_last = (step_r == CW'(MAX_TAPS - 1));

  assign tap_en    = (step_r < n_act);
  assign prod_full = coef_r[0] * dl_r[0];
  assign prod_ext  = EW'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TAPCNT_RESET;
    end else if (cfg_wr) begin
      tap_count_r <= cfg_data;
    end
  end

  // tap and delay stores rotate one place per MAC step, aligned again after MAX_TAPS
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        coef_r[i] <= '0;
        dl_r[i]   <= '0;
      end
    end else begin
      if (cmd.coef_wr) begin
        for (int i = 0; i < MAX_TAPS; i++) begin
          if (32'(tap_index) == i) coef_r[i] <= samp;
        end
      end else if (cmd.mac_step) begin
        for (int i = 0; i < MAX_TAPS - 1; i++) coef_r[i] <= coef_r[i+1];
        coef_r[MAX_TAPS-1] <= coef_r[0];
      end

      if (cmd.clear_dl) begin
        for (int i = 0; i < MAX_TAPS; i++) dl_r[i] <= '0;
      end else if (cmd.shift_en) begin
        for (int i = MAX_TAPS - 1; i > 0; i--) dl_r[i] <= dl_r[i-1];
        dl_r[0] <= cmd.shift_zero ? '0 : samp;
      end else if (cmd.mac_step) begin
        for (int i = 0; i < MAX_TAPS - 1; i++) dl_r[i] <= dl_r[i+1];
        dl_r[MAX_TAPS-1] <= dl_r[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      rem_r  <= '0;
    end else begin
      if (cmd.mac_clear)     step_r <= '0;
      else if (cmd.mac_step) step_r <= step_r + CW'(1);
      if (cmd.load_rem)      rem_r  <= n_act - CW'(1);
      else if (cmd.dec_rem)  rem_r  <= rem_r - CW'(1);
    end
  end

  // product register, then accumulate modulo 2^OUT_W
  always_ff @(posedge clk) begin
    if (cmd.mac_clear) begin
      prod_r <= '0;
      acc_r  <= '0;
    end else begin
      if (cmd.mac_step) prod_r <= tap_en ? prod_full : '0;
      if (cmd.mac_step || cmd.acc_final) acc_r <= acc_r + prod_ext[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      filtered_r <= $signed(acc_r);
      is_last_r  <= cmd.out_last;
    end
  end

  assign filtered = filtered_r;
  assign is_last  = is_last_r;

endmodule
`default_nettype wire

>>> rtl/fir_linear_convolution_unit.sv
// FIR filter computing the full linear convolution of a sample stream with a
// stored tap set. Three valid/ready channels:
//   in_ch  : action LOAD writes value into tap tap_index (no result), SAMPLE
//            shifts value into the delay line and yields one output, FLUSH
//            shifts in zeros for active_taps-1 tail outputs, flags the final
//            one is_last and then clears the delay line. Code 3 is dropped.
//   out_ch : filtered (36-bit two's complement, wraps) and is_last.
//   cfg_ch : tap_count, always ready; write it only while the filter is idle.
// One multiply-accumulate unit walks all MAX_TAPS tap positions, one per
// cycle, as the tap and delay registers rotate past it. A load leaves the
// filter idle. A sample runs the MAC, add and result states; the next item
// is taken only once its result is in the output register. A flush runs the
// shift, MAC, add and result states once per tail output.
// The result register holds while out_ch.ready is low; the block still takes
// the next item, but parks its next result until the register is freed.
// Reset (rst_n low, synchronous) zeroes taps and delay line, sets tap_count
// to 10 and drops out_ch.valid.
`default_nettype none
module fir_linear_convolution_unit import flc_pkg::*; #(
  parameter int MAX_TAPS    = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  flc_in_if.sink    in_ch,
  flc_out_if.source out_ch,
  flc_cfg_if.sink   cfg_ch
);

  flc_cmd_t cmd;
  flc_sts_t sts;
  logic     cfg_wr;

  // config is taken on every cycle; the contract keeps it to idle periods
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid;

  flc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  flc_datapath #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .cfg_data  (cfg_ch.data),
    .tap_index (in_ch.tap_index),
    .value     (in_ch.value),
    .cmd       (cmd),
    .sts       (sts),
    .filtered  (out_ch.filtered),
    .is_last   (out_ch.is_last)
  );

endmodule
`default_nettype wire

>>> rtl/flc_checker.sv
`default_nettype none
`include "fir_linear_convolution_unit_defines.svh"
module flc_checker import flc_pkg::*; (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic [ACTION_W-1:0]       in_action,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic signed [OUT_W-1:0]   out_filtered,
  input wire logic                      out_is_last
);

  // stalled result must hold
  `FLC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_filtered) && $stable(out_is_last), "result changed while stalled")

  // a tap load never produces a result
  `FLC_ASSERT(a_load_silent, in_valid && in_ready && (in_action == ACT_LOAD) && !out_valid |=> !out_valid, "tap load produced a result")

  // a sample keeps the filter busy while it is summed
  `FLC_ASSERT(a_sample_busy, in_valid && in_ready && (in_action == ACT_SAMPLE) |=> !in_ready, "input taken during tap sum")

  // reset leaves the filter ready and empty
  `FLC_ASSERT_ALWAYS(a_reset_state, !rst_n |=> in_ready && !out_valid, "bad state after reset")

endmodule

bind fir_linear_convolution_unit flc_checker u_flc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_action    (in_ch.action),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_filtered (out_ch.filtered),
  .out_is_last  (out_ch.is_last)
);
`default_nettype wire
